// ----- design/e2c_pkg.sv -----
`default_nettype none
package e2c_pkg;

	localparam int DEF_MAX_FACE_WIDTH  = 4096;
	localparam int DEF_MAX_PANO_DIM    = 8192;
	localparam int DEF_ANGLE_FRAC_BITS = 18;

	// vector datapath: components scaled by 2^16, room for cordic growth
	localparam int VEC_GUARD = 16;
	localparam int VEC_W     = 40;
	localparam int DIR_W     = 16;
	localparam int YGAIN_W   = 34;
	localparam int GAIN_Q16  = 107922;

	localparam int FACE_W  = 3;
	localparam int COORD_W = 12;
	localparam int INDEX_W = 24;
	localparam int PANO_W  = 13;
	localparam int FW_W    = 13;
	localparam int PDIM_W  = 14;
	localparam int SIZE_W  = 16;

	localparam int S_TDATA_W = 32;
	localparam int M_TDATA_W = 56;

	typedef enum logic [1:0] {
		REG_FACE_WIDTH  = 2'd0,
		REG_PANO_WIDTH  = 2'd1,
		REG_PANO_HEIGHT = 2'd2
	} reg_index_t;

	localparam logic [FACE_W-1:0] FACE_RIGHT   = 3'd0;
	localparam logic [FACE_W-1:0] FACE_UP      = 3'd1;
	localparam logic [FACE_W-1:0] FACE_FORWARD = 3'd2;
	localparam logic [FACE_W-1:0] FACE_LEFT    = 3'd3;
	localparam logic [FACE_W-1:0] FACE_DOWN    = 3'd4;
	localparam logic [FACE_W-1:0] FACE_BACK    = 3'd5;

	// per-item control travelling beside the cordic datapath
	typedef struct packed {
		logic [FACE_W-1:0]  face;
		logic [INDEX_W-1:0] index;
		logic               xz_zero;
		logic               y_pos;
		logic               y_neg;
	} side_t;

	// atan(2^-i) with pi = 2^31, rounded to nearest at pi = 2^frac
	function automatic longint step_angle(input int i, input int frac);
		longint t;
		int     s;
		s = 31 - frac;
		case (i)
			0:  t = 536870912;
			1:  t = 316933406;
			2:  t = 167458907;
			3:  t = 85004756;
			4:  t = 42667331;
			5:  t = 21354465;
			6:  t = 10679838;
			7:  t = 5340245;
			8:  t = 2670163;
			9:  t = 1335087;
			10: t = 667544;
			11: t = 333772;
			12: t = 166886;
			13: t = 83443;
			14: t = 41722;
			15: t = 20861;
			16: t = 10430;
			17: t = 5215;
			18: t = 2608;
			19: t = 1304;
			20: t = 652;
			21: t = 326;
			22: t = 163;
			23: t = 81;
			24: t = 41;
			25: t = 20;
			26: t = 10;
			27: t = 5;
			28: t = 3;
			29: t = 1;
			30: t = 1;
			default: t = 0;
		endcase
		return (t + (longint'(1) << (s - 1))) >>> s;
	endfunction

endpackage
`default_nettype wire

// ----- design/e2c_front.sv -----
`default_nettype none
module e2c_front import e2c_pkg::*; #(
	parameter int MAX_FACE_WIDTH  = DEF_MAX_FACE_WIDTH,
	parameter int ANGLE_FRAC_BITS = DEF_ANGLE_FRAC_BITS,
	parameter int AW              = DEF_ANGLE_FRAC_BITS + 4
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 en,
	input  wire logic                 vin,
	input  wire logic [FACE_W-1:0]    face,
	input  wire logic [COORD_W-1:0]   col,
	input  wire logic [COORD_W-1:0]   row,
	input  wire logic [FW_W-1:0]      face_width,
	output logic                      vout,
	output logic signed [VEC_W-1:0]   vx,
	output logic signed [VEC_W-1:0]   vy,
	output logic signed [AW-1:0]      a0,
	output logic signed [VEC_W-1:0]   ygain,
	output side_t                     side
);
	localparam logic [SIZE_W-1:0] MAXW = SIZE_W'(MAX_FACE_WIDTH);
	localparam logic signed [AW-1:0] PI = AW'(longint'(1) <<< ANGLE_FRAC_BITS);
	localparam logic signed [YGAIN_W-1:0] GAIN = YGAIN_W'(GAIN_Q16);

	logic [SIZE_W-1:0]       fw_ext;
	logic [FW_W-1:0]         w;
	logic signed [DIR_W-1:0] wm1;
	logic [24:0]             idx_full;

	logic                    valid_s1;
	logic [FACE_W-1:0]       face_s1;
	logic signed [DIR_W-1:0] lx_s1, ly_s1, lz_s1;
	logic [INDEX_W-1:0]      index_s1;

	logic signed [DIR_W-1:0] x, y, z, mag, vyd;
	logic signed [AW-1:0]    off;

	assign fw_ext   = SIZE_W'(face_width);
	assign w        = (fw_ext > MAXW) ? MAXW[FW_W-1:0] : face_width;
	assign wm1      = $signed(DIR_W'(w)) - DIR_W'(1);
	assign idx_full = 25'(row) * 25'(w) + 25'(col);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			vout     <= 1'b0;
		end else if (en) begin
			valid_s1 <= vin;
			vout     <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			face_s1  <= face;
			lx_s1    <= $signed(DIR_W'({col, 1'b0})) - wm1;
			ly_s1    <= $signed(DIR_W'({row, 1'b0})) - wm1;
			lz_s1    <= wm1;
			index_s1 <= idx_full[INDEX_W-1:0];
		end
	end

	// fixed face rotation as a signed permutation
	always_comb begin
		case (face_s1)
			FACE_RIGHT: begin x = lz_s1;  y = ly_s1;  z = -lx_s1; end
			FACE_UP:    begin x = lx_s1;  y = -lz_s1; z = ly_s1;  end
			FACE_LEFT:  begin x = -lz_s1; y = ly_s1;  z = lx_s1;  end
			FACE_DOWN:  begin x = lx_s1;  y = lz_s1;  z = -ly_s1; end
			FACE_BACK:  begin x = -lx_s1; y = ly_s1;  z = -lz_s1; end
			default:    begin x = lx_s1;  y = ly_s1;  z = lz_s1;  end
		endcase
		if (z < 0) begin
			mag = -z;
			vyd = -x;
			off = (x >= 0) ? PI : -PI;
		end else begin
			mag = z;
			vyd = x;
			off = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vx           <= VEC_W'(mag) <<< VEC_GUARD;
			vy           <= VEC_W'(vyd) <<< VEC_GUARD;
			a0           <= off;
			ygain        <= VEC_W'(YGAIN_W'(y) * GAIN);
			side.face    <= face_s1;
			side.index   <= index_s1;
			side.xz_zero <= (x == 0) && (z == 0);
			side.y_pos   <= y > 0;
			side.y_neg   <= y < 0;
		end
	end
endmodule
`default_nettype wire

// ----- design/e2c_cordic_stage.sv -----
`default_nettype none
module e2c_cordic_stage import e2c_pkg::*; #(
	parameter int STEP            = 0,
	parameter int ANGLE_FRAC_BITS = DEF_ANGLE_FRAC_BITS,
	parameter int AW              = DEF_ANGLE_FRAC_BITS + 4
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               en,
	input  wire logic               vin,
	input  wire logic signed [VEC_W-1:0] xin,
	input  wire logic signed [VEC_W-1:0] yin,
	input  wire logic signed [AW-1:0]    ain,
	output logic                    vout,
	output logic signed [VEC_W-1:0] xout,
	output logic signed [VEC_W-1:0] yout,
	output logic signed [AW-1:0]    aout
);
	localparam logic signed [AW-1:0] ANG = AW'(step_angle(STEP, ANGLE_FRAC_BITS));

	logic signed [VEC_W-1:0] dx, dy;

	// arithmetic shift floors, as the rotation needs
	assign dx = yin >>> STEP;
	assign dy = xin >>> STEP;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vout <= 1'b0;
		end else if (en) begin
			vout <= vin;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (yin >= 0) begin
				xout <= xin + dx;
				yout <= yin - dy;
				aout <= ain + ANG;
			end else begin
				xout <= xin - dx;
				yout <= yin + dy;
				aout <= ain - ANG;
			end
		end
	end
endmodule
`default_nettype wire

// ----- design/e2c_map.sv -----
`default_nettype none
module e2c_map import e2c_pkg::*; #(
	parameter int MAX_PANO_DIM    = DEF_MAX_PANO_DIM,
	parameter int ANGLE_FRAC_BITS = DEF_ANGLE_FRAC_BITS,
	parameter int AW              = DEF_ANGLE_FRAC_BITS + 4
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                en,
	input  wire logic                vin,
	input  wire side_t               side,
	input  wire logic signed [AW-1:0] phi,
	input  wire logic signed [AW-1:0] theta,
	input  wire logic [PDIM_W-1:0]   pano_width,
	input  wire logic [PDIM_W-1:0]   pano_height,
	output logic                     vout,
	output logic [FACE_W-1:0]        face_out,
	output logic [INDEX_W-1:0]       texel_index,
	output logic [PANO_W-1:0]        pano_x,
	output logic [PANO_W-1:0]        pano_y
);
	localparam int NW = AW + 1;
	localparam int PW = AW + SIZE_W;
	localparam logic signed [NW-1:0] PI   = NW'(longint'(1) <<< ANGLE_FRAC_BITS);
	localparam logic signed [NW-1:0] HALF = NW'(longint'(1) <<< (ANGLE_FRAC_BITS - 1));
	localparam logic [SIZE_W-1:0]    MAXP = SIZE_W'(MAX_PANO_DIM);

	logic signed [NW-1:0] num_x, num_y;
	logic [SIZE_W-1:0]    wx, hy;
	logic [PW-1:0]        qx, qy;

	logic                 valid_s1, valid_s2;
	logic [AW-1:0]        nx_s1, ny_s1;
	logic [SIZE_W-1:0]    sx_s1, sy_s1, sx_s2, sy_s2;
	logic [PW-1:0]        px_s2, py_s2;
	logic [FACE_W-1:0]    face_s1, face_s2;
	logic [INDEX_W-1:0]   index_s1, index_s2;

	assign num_x = NW'(phi) + PI;
	assign num_y = NW'(theta) + HALF;
	assign wx    = (SIZE_W'(pano_width) > MAXP) ? MAXP : SIZE_W'(pano_width);
	assign hy    = (SIZE_W'(pano_height) > MAXP) ? MAXP : SIZE_W'(pano_height);
	assign qx    = px_s2 >> (ANGLE_FRAC_BITS + 1);
	assign qy    = py_s2 >> ANGLE_FRAC_BITS;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			vout     <= 1'b0;
		end else if (en) begin
			valid_s1 <= vin;
			valid_s2 <= valid_s1;
			vout     <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nx_s1       <= (num_x <= 0) ? '0 : num_x[AW-1:0];
			ny_s1       <= (num_y <= 0) ? '0 : num_y[AW-1:0];
			sx_s1       <= wx;
			sy_s1       <= hy;
			face_s1     <= side.face;
			index_s1    <= side.index;
			px_s2       <= PW'(nx_s1) * PW'(sx_s1);
			py_s2       <= PW'(ny_s1) * PW'(sy_s1);
			sx_s2       <= sx_s1;
			sy_s2       <= sy_s1;
			face_s2     <= face_s1;
			index_s2    <= index_s1;
			face_out    <= face_s2;
			texel_index <= index_s2;
			if (sx_s2 == '0)
				pano_x <= '0;
			else if (qx > PW'(sx_s2 - SIZE_W'(1)))
				pano_x <= PANO_W'(sx_s2 - SIZE_W'(1));
			else
				pano_x <= qx[PANO_W-1:0];
			if (sy_s2 == '0)
				pano_y <= '0;
			else if (qy > PW'(sy_s2 - SIZE_W'(1)))
				pano_y <= PANO_W'(sy_s2 - SIZE_W'(1));
			else
				pano_y <= qy[PANO_W-1:0];
		end
	end
endmodule
`default_nettype wire

// ----- design/equirect_to_cubemap_coord.sv -----
// throughput: one item per cycle; every stage advances together when the output is free
// the pipe length is set mainly by the two unrolled cordic chains, one register per rotation step
// reset: arst_n clears all valid bits and loads the default face and panorama sizes
`default_nettype none
module equirect_to_cubemap_coord import e2c_pkg::*; #(
	parameter int MAX_FACE_WIDTH  = DEF_MAX_FACE_WIDTH,
	parameter int MAX_PANO_DIM    = DEF_MAX_PANO_DIM,
	parameter int ANGLE_FRAC_BITS = DEF_ANGLE_FRAC_BITS
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [S_TDATA_W-1:0] s_tdata,  // face, col, row
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic [M_TDATA_W-1:0]      m_tdata,  // face_out, texel_index, pano_x, pano_y
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [1:0]           cfg_index,
	input  wire logic [PDIM_W-1:0]    cfg_data
);
	localparam int N  = ANGLE_FRAC_BITS + 2;
	localparam int AW = ANGLE_FRAC_BITS + 4;
	localparam logic signed [AW-1:0] HALF_PI = AW'(longint'(1) <<< (ANGLE_FRAC_BITS - 1));

	// configuration registers
	logic [FW_W-1:0]   face_width_q;
	logic [PDIM_W-1:0] pano_width_q;
	logic [PDIM_W-1:0] pano_height_q;

	logic en;

	// azimuth chain: index 0 is the front end output
	logic                    az_v    [0:N];
	logic signed [VEC_W-1:0] az_x    [0:N];
	logic signed [VEC_W-1:0] az_y    [0:N];
	logic signed [AW-1:0]    az_a    [0:N];
	logic signed [VEC_W-1:0] az_yg   [0:N];
	side_t                   az_side [0:N];

	// elevation chain, fed by the azimuth magnitude
	logic                    el_v    [0:N];
	logic signed [VEC_W-1:0] el_x    [0:N];
	logic signed [VEC_W-1:0] el_y    [0:N];
	logic signed [AW-1:0]    el_a    [0:N];
	logic signed [AW-1:0]    el_phi  [0:N];
	side_t                   el_side [0:N];

	logic signed [AW-1:0] phi_f, theta_f;

	logic [FACE_W-1:0]  face_out;
	logic [INDEX_W-1:0] texel_index;
	logic [PANO_W-1:0]  pano_x, pano_y;

	// whole pipe moves while the output register is empty or being taken
	assign en        = !m_tvalid || m_tready;
	assign s_tready  = en;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			face_width_q  <= FW_W'(512);
			pano_width_q  <= PDIM_W'(2048);
			pano_height_q <= PDIM_W'(1024);
		end else if (cfg_valid) begin
			case (reg_index_t'(cfg_index))
				REG_FACE_WIDTH:  face_width_q  <= cfg_data[FW_W-1:0];
				REG_PANO_WIDTH:  pano_width_q  <= cfg_data;
				REG_PANO_HEIGHT: pano_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// direction, face rotation and half-plane fold
	e2c_front #(
		.MAX_FACE_WIDTH (MAX_FACE_WIDTH),
		.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS),
		.AW             (AW)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.vin       (s_tvalid),
		.face      (s_tdata[2:0]),
		.col       (s_tdata[14:3]),
		.row       (s_tdata[26:15]),
		.face_width(face_width_q),
		.vout      (az_v[0]),
		.vx        (az_x[0]),
		.vy        (az_y[0]),
		.a0        (az_a[0]),
		.ygain     (az_yg[0]),
		.side      (az_side[0])
	);

	for (genvar i = 0; i < N; i++) begin : g_az
		e2c_cordic_stage #(
			.STEP(i), .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .AW(AW)
		) u_stage (
			.clk(clk), .arst_n(arst_n), .en(en),
			.vin(az_v[i]), .xin(az_x[i]), .yin(az_y[i]), .ain(az_a[i]),
			.vout(az_v[i+1]), .xout(az_x[i+1]), .yout(az_y[i+1]), .aout(az_a[i+1])
		);
		always_ff @(posedge clk) begin
			if (en) begin
				az_yg[i+1]   <= az_yg[i];
				az_side[i+1] <= az_side[i];
			end
		end
	end

	assign el_v[0]    = az_v[N];
	assign el_x[0]    = az_x[N];
	assign el_y[0]    = az_yg[N];
	assign el_a[0]    = '0;
	assign el_phi[0]  = az_a[N];
	assign el_side[0] = az_side[N];

	for (genvar i = 0; i < N; i++) begin : g_el
		e2c_cordic_stage #(
			.STEP(i), .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .AW(AW)
		) u_stage (
			.clk(clk), .arst_n(arst_n), .en(en),
			.vin(el_v[i]), .xin(el_x[i]), .yin(el_y[i]), .ain(el_a[i]),
			.vout(el_v[i+1]), .xout(el_x[i+1]), .yout(el_y[i+1]), .aout(el_a[i+1])
		);
		always_ff @(posedge clk) begin
			if (en) begin
				el_phi[i+1]  <= el_phi[i];
				el_side[i+1] <= el_side[i];
			end
		end
	end

	// straight up or down: azimuth undefined, pinned to zero
	always_comb begin
		phi_f   = el_phi[N];
		theta_f = el_a[N];
		if (el_side[N].xz_zero) begin
			phi_f = '0;
			if (el_side[N].y_pos)
				theta_f = HALF_PI;
			else if (el_side[N].y_neg)
				theta_f = -HALF_PI;
			else
				theta_f = '0;
		end
	end

	// angle to pixel scaling and clamp, last stage is the output register
	e2c_map #(
		.MAX_PANO_DIM   (MAX_PANO_DIM),
		.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS),
		.AW             (AW)
	) u_map (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.vin        (el_v[N]),
		.side       (el_side[N]),
		.phi        (phi_f),
		.theta      (theta_f),
		.pano_width (pano_width_q),
		.pano_height(pano_height_q),
		.vout       (m_tvalid),
		.face_out   (face_out),
		.texel_index(texel_index),
		.pano_x     (pano_x),
		.pano_y     (pano_y)
	);

	assign m_tdata = {3'b000, pano_y, pano_x, texel_index, face_out};

`ifndef SYNTHESIS
	a_x_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && pano_width_q != '0 |-> 14'(m_tdata[39:27]) < pano_width_q)
		else $error("pano_x beyond panorama width");

	a_y_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && pano_height_q != '0 |-> 14'(m_tdata[52:40]) < pano_height_q)
		else $error("pano_y beyond panorama height");

	a_zero_width: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && pano_width_q == '0 |-> m_tdata[39:27] == '0)
		else $error("pano_x not zero for empty panorama");

	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready)
		else $error("input taken while result stalled");
`endif
endmodule
`default_nettype wire
